// ===== sv/assert_macros.svh =====
// Assertion macros shared by the closure RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/btc_pkg.sv =====
// Package for boolean_transitive_closure: sizes, write request type, helpers.
// No dependencies.
package btc_pkg;

    localparam int MaxVertices      = 64;
    localparam int IdxW             = $clog2(MaxVertices);
    localparam int VertexW          = 6;
    localparam int RowW             = 64;
    localparam int CountW           = 7;
    localparam int VertexCountReset = 64;

    typedef struct packed {
        logic            en;
        logic            set_only;
        logic [IdxW-1:0] addr;
        logic [RowW-1:0] data;
    } btc_wr_t;

    // index of the highest vertex in use, vertex count clamped to 1..MaxVertices
    function automatic logic [IdxW-1:0] btc_active_last(input logic [CountW-1:0] count);
        logic [IdxW-1:0] res;
        if (count == '0)
            res = '0;
        else if (count > CountW'(MaxVertices))
            res = IdxW'(MaxVertices - 1);
        else
            res = IdxW'(count - CountW'(1));
        return res;
    endfunction

endpackage

// ===== sv/btc_in_if.sv =====
// Edge input channel: valid/ready plus one directed edge per beat.
// Depends on btc_pkg.
interface btc_in_if import btc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VertexW-1:0] src_vertex;
    logic [VertexW-1:0] dst_vertex;
    logic               edge_valid;
    logic               graph_end;

    modport source (output valid, src_vertex, dst_vertex, edge_valid, graph_end,
                    input ready);
    modport sink   (input valid, src_vertex, dst_vertex, edge_valid, graph_end,
                    output ready);
endinterface

// ===== sv/btc_out_if.sv =====
// Row output channel: valid/ready plus one reachability row per beat.
// Depends on btc_pkg.
interface btc_out_if import btc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VertexW-1:0] row_index;
    logic [RowW-1:0]    reach_bits;
    logic               last_row;

    modport source (output valid, row_index, reach_bits, last_row, input ready);
    modport sink   (input valid, row_index, reach_bits, last_row, output ready);
endinterface

// ===== sv/btc_matrix.sv =====
// Adjacency bit matrix: one synchronous RAM with per-row valid flops.
// Depends on btc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module btc_matrix import btc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  btc_wr_t         wr,
    input  logic            rd_en,
    input  logic [IdxW-1:0] rd_addr,
    output logic [RowW-1:0] rd_data,
    input  logic            clear_all
);

    logic [RowW-1:0]        mem [MaxVertices];
    logic [RowW-1:0]        q_reg;
    logic [IdxW-1:0]        rd_addr_reg;
    logic [MaxVertices-1:0] row_valid_reg;
    logic [MaxVertices-1:0] row_valid_next;
    logic [RowW-1:0]        wmask;

    // first write to an invalid row overwrites the whole row
    assign wmask = (wr.set_only && row_valid_reg[wr.addr]) ? wr.data : '1;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int b = 0; b < RowW; b++)
            begin
                if (wmask[b])
                    mem[wr.addr][b] <= wr.data[b];
            end
        end
        if (rd_en)
        begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (clear_all)
            row_valid_next = '0;
        else if (wr.en)
            row_valid_next[wr.addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else
            row_valid_reg <= row_valid_next;
    end

    assign rd_data = row_valid_reg[rd_addr_reg] ? q_reg : '0;

    `ASSERT_NOW(a_no_rw_collide, rd_en && wr.en, rd_addr != wr.addr, "read and write hit same row")
    `ASSERT_NOW(a_clear_no_wr, clear_all, !wr.en, "write during matrix clear")

endmodule

// ===== sv/boolean_transitive_closure.sv =====
// Top level: edge loading, Warshall closure sequencer and row emit.
// Depends on btc_pkg, btc_in_if, btc_out_if, btc_matrix, assert_macros.svh.
//
//  channel   dir  beat
//  edges     in   src_vertex, dst_vertex, edge_valid, graph_end
//  rows      out  row_index, reach_bits, last_row
//  cfg       in   vertex_count (write only, cfg_wr_en/cfg_wr_data)
//
// Edges load one per cycle while idle, one bit-masked RAM write per valid in-range edge.
// Closure: per pivot one read, one latch, n row read/writes
// through the single RAM read port and one drain state.
// Emit: per row a read, a latch and a wait for any stall on rows; no edge is taken meanwhile.
// Reset clears the row valid flops at once; no clearing pass.
`include "assert_macros.svh"

module boolean_transitive_closure import btc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CountW-1:0] cfg_wr_data,
    btc_in_if.sink            edges,
    btc_out_if.source         rows
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_PIV_RD    = 8'b0000_0010,
        S_PIV_LAT   = 8'b0000_0100,
        S_SWEEP     = 8'b0000_1000,
        S_DRAIN     = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_LAT  = 8'b0100_0000,
        S_EMIT_WAIT = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CountW-1:0]  vertex_count_reg;
    logic [IdxW-1:0]    top_idx_reg, top_idx_next;
    logic [IdxW-1:0]    k_reg, k_next;
    logic [IdxW-1:0]    s_reg, s_next;
    logic               ret_v_reg;
    logic [IdxW-1:0]    ret_addr_reg;
    logic [RowW-1:0]    pivot_reg;
    logic               out_valid_reg, out_valid_next;
    logic [VertexW-1:0] row_index_reg;
    logic [RowW-1:0]    reach_reg;
    logic               last_row_reg;
    logic [IdxW-1:0]    cur_last;
    logic               edge_acc;
    logic               edge_ok;
    logic               out_acc;
    btc_wr_t            wr;
    logic               rd_en;
    logic [IdxW-1:0]    rd_addr;
    logic [RowW-1:0]    rd_data;
    logic               clear_all;
    logic [RowW-1:0]    col_mask;

    btc_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .clear_all (clear_all)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= CountW'(VertexCountReset);
        else if (cfg_wr_en)
            vertex_count_reg <= cfg_wr_data;
    end

    assign cur_last     = btc_active_last(vertex_count_reg);
    assign edges.ready  = (state_reg == S_IDLE);
    assign edge_acc     = edges.valid && edges.ready;
    assign edge_ok      = edge_acc && edges.edge_valid
                          && (CountW'(edges.src_vertex) <= CountW'(cur_last))
                          && (CountW'(edges.dst_vertex) <= CountW'(cur_last));
    assign out_acc      = rows.valid && rows.ready;

    always_comb
    begin
        for (int v = 0; v < RowW; v++)
            col_mask[v] = (v <= int'(top_idx_reg));
    end

    always_comb
    begin
        wr          = '0;
        rd_en       = 1'b0;
        rd_addr     = s_reg;
        clear_all   = 1'b0;
        state_next  = state_reg;
        top_idx_next = top_idx_reg;
        k_next      = k_reg;
        s_next      = s_reg;
        out_valid_next = out_valid_reg;

        // row returned by the sweep: OR in the pivot row when bit k is set
        if (ret_v_reg && rd_data[k_reg])
        begin
            wr.en       = 1'b1;
            wr.set_only = 1'b0;
            wr.addr     = ret_addr_reg;
            wr.data     = rd_data | pivot_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                wr.en       = edge_ok;
                wr.set_only = 1'b1;
                wr.addr     = IdxW'(edges.src_vertex);
                wr.data     = RowW'(1) << edges.dst_vertex;
                if (edge_acc && edges.graph_end)
                begin
                    top_idx_next = cur_last;
                    k_next       = '0;
                    state_next   = S_PIV_RD;
                end
            end
            S_PIV_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = S_PIV_LAT;
            end
            S_PIV_LAT:
            begin
                s_next     = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                rd_en   = 1'b1;
                rd_addr = s_reg;
                if (s_reg == top_idx_reg)
                    state_next = S_DRAIN;
                else
                    s_next = s_reg + IdxW'(1);
            end
            S_DRAIN:
            begin
                // interlock: last write lands before the next pivot read
                if (k_reg == top_idx_reg)
                begin
                    s_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    k_next     = k_reg + IdxW'(1);
                    state_next = S_PIV_RD;
                end
            end
            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = s_reg;
                state_next = S_EMIT_LAT;
            end
            S_EMIT_LAT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (s_reg == top_idx_reg)
                    begin
                        clear_all  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + IdxW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_idx_reg   <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            ret_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_idx_reg   <= top_idx_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            ret_v_reg     <= (state_reg == S_SWEEP);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWEEP)
            ret_addr_reg <= s_reg;
        if (state_reg == S_PIV_LAT)
            pivot_reg <= rd_data;
        if (state_reg == S_EMIT_LAT)
        begin
            row_index_reg <= VertexW'(s_reg);
            reach_reg     <= rd_data & col_mask;
            last_row_reg  <= (s_reg == top_idx_reg);
        end
    end

    assign rows.valid      = out_valid_reg;
    assign rows.row_index  = row_index_reg;
    assign rows.reach_bits = reach_reg;
    assign rows.last_row   = last_row_reg;

    `ASSERT_NOW(a_no_load_during_emit, edges.ready, !rows.valid, "edge taken while row pending")
    `ASSERT_NEXT(a_idle_after_last, out_acc && rows.last_row, edges.ready, "not idle after last row")
    `ASSERT_NOW(a_pivot_in_range, state_reg == S_PIV_LAT, k_reg <= top_idx_reg, "pivot out of range")

endmodule
